// ===== rtl/qrs_pkg.sv =====
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;

    // Discriminant magnitude and its integer square root.
    localparam int RAD_W  = 66;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    // Divider: numerator integer part, divisor |2a| and partial remainder.
    localparam int NUM_INT_W = 35;
    localparam int DIV_D_W   = COEF_W + 1;
    localparam int DIV_R_W   = DIV_D_W + 1;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2
    } t_root_kind;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_req;

    typedef struct packed {
        t_root_kind               root_kind;
        logic signed [COEF_W-1:0] first_value;
        logic signed [COEF_W-1:0] second_value;
        logic                     zero_lead_error;
        logic                     saturated;
    } t_rsp;

    // Side information that rides along the square root pipeline.
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic                     zero_lead;
        t_root_kind               kind;
    } t_side;

    // Side information that rides along the divider pipeline.
    typedef struct packed {
        logic       zero_lead;
        t_root_kind kind;
        logic       neg1;
        logic       neg2;
    } t_div_side;

endpackage

// ===== rtl/quadratic_root_solver_core.sv =====
// Quadratic root solver for a*x^2 + b*x + c = 0 with signed fixed-point
// coefficients (FRAC_BITS fraction bits, 32 bits each).
//
// A request enters on i_valid/i_req and is taken at any edge where o_stall is
// low. One result leaves on o_valid/o_rsp and is taken where i_stall is low.
// The block takes a new request every cycle while o_stall is low; requests
// never wait on each other. The square root pipeline gives one root bit per
// stage over 33 stages, and the divider pipeline one quotient bit per stage.
//
// The whole pipeline advances together. It holds only when the output
// register is full and the receiver stalls; o_stall then rises and every
// stage keeps its contents, so nothing is lost or repeated. Empty stages do
// not hold anything back while the output register is free.
//
// Reset clears every stage valid bit and the output valid; the data
// registers are not reset. A zero coefficient a yields zero roots with
// zero_lead_error set.
module quadratic_root_solver_core import qrs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int NUM_W = NUM_INT_W + FRAC_BITS;
    localparam int SQ_SBW = $bits(t_side);
    localparam int DV_SBW = $bits(t_div_side);

    // Global advance: the pipeline moves unless a finished result is blocked.
    logic w_en;
    logic r_out_valid;
    t_rsp r_rsp;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // Discriminant: products, then the exact wide subtraction and its sign.
    logic             w_dc_valid;
    logic [RAD_W-1:0] w_dc_rad;
    t_side            w_dc_side;

    qrs_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (w_dc_valid),
        .o_rad   (w_dc_rad),
        .o_side  (w_dc_side)
    );

    // Floor of the square root of |D|.
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_sq_root;
    logic [SQ_SBW-1:0] w_sq_sb;
    t_side             w_sq_side;

    qrs_sqrt #(.SBW(SQ_SBW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dc_valid),
        .i_rad   (w_dc_rad),
        .i_sb    (w_dc_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_sb    (w_sq_sb)
    );

    assign w_sq_side = t_side'(w_sq_sb);

    // Numerator selection. Both dividers work on magnitudes; the sign of each
    // quotient is the sign of its numerator against the sign of a, which gives
    // truncation toward zero.
    logic signed [NUM_INT_W:0] n_negb;
    logic signed [NUM_INT_W:0] n_root;
    logic signed [NUM_INT_W:0] n_num1;
    logic signed [NUM_INT_W:0] n_num2;
    logic signed [NUM_INT_W:0] n_abs1;
    logic signed [NUM_INT_W:0] n_abs2;
    logic signed [DIV_D_W-1:0] n_den_s;

    always_comb begin
        n_negb  = -(NUM_INT_W+1)'(w_sq_side.coef_b);
        n_root  = $signed({{(NUM_INT_W+1-ROOT_W){1'b0}}, w_sq_root});
        n_num1  = n_negb;
        n_num2  = n_negb;
        case (w_sq_side.kind)
            KIND_TWO_REAL: begin
                n_num1 = n_negb + n_root;
                n_num2 = n_negb - n_root;
            end
            KIND_COMPLEX: begin
                n_num2 = n_root;
            end
            default: begin
                n_num1 = n_negb;
                n_num2 = n_negb;
            end
        endcase
        n_abs1  = n_num1[NUM_INT_W] ? -n_num1 : n_num1;
        n_abs2  = n_num2[NUM_INT_W] ? -n_num2 : n_num2;
        n_den_s = {w_sq_side.coef_a, 1'b0};
    end

    logic                 r_pp_valid;
    logic [NUM_INT_W-1:0] r_pp_mag1;
    logic [NUM_INT_W-1:0] r_pp_mag2;
    logic [DIV_D_W-1:0]   r_pp_den;
    t_div_side            r_pp_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid <= 1'b0;
        end else if (w_en) begin
            r_pp_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp_mag1           <= n_abs1[NUM_INT_W-1:0];
            r_pp_mag2           <= n_abs2[NUM_INT_W-1:0];
            r_pp_den            <= n_den_s[DIV_D_W-1] ? DIV_D_W'(-n_den_s)
                                                      : DIV_D_W'(n_den_s);
            r_pp_side.zero_lead <= w_sq_side.zero_lead;
            r_pp_side.kind      <= w_sq_side.kind;
            r_pp_side.neg1      <= n_num1[NUM_INT_W] ^ w_sq_side.coef_a[COEF_W-1];
            r_pp_side.neg2      <= n_num2[NUM_INT_W] ^ w_sq_side.coef_a[COEF_W-1];
        end
    end

    // Quotients carry FRAC_BITS fraction bits: the numerators are scaled up.
    logic              w_dv_valid;
    logic [NUM_W-1:0]  w_dv_quo1;
    logic [NUM_W-1:0]  w_dv_quo2;
    logic [DV_SBW-1:0] w_dv_sb;
    t_div_side         w_dv_side;

    qrs_div #(.NUM_W(NUM_W), .SBW(DV_SBW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_pp_valid),
        .i_num1  ({r_pp_mag1, {FRAC_BITS{1'b0}}}),
        .i_num2  ({r_pp_mag2, {FRAC_BITS{1'b0}}}),
        .i_den   (r_pp_den),
        .i_sb    (r_pp_side),
        .o_valid (w_dv_valid),
        .o_quo1  (w_dv_quo1),
        .o_quo2  (w_dv_quo2),
        .o_sb    (w_dv_sb)
    );

    assign w_dv_side = t_div_side'(w_dv_sb);

    // Apply the sign and clip to the signed 32-bit range.
    logic [COEF_W-1:0] n_val1;
    logic [COEF_W-1:0] n_val2;
    logic              n_sat1;
    logic              n_sat2;
    t_rsp              n_rsp;

    always_comb begin
        if (!w_dv_side.neg1) begin
            n_sat1 = (w_dv_quo1[NUM_W-1:COEF_W-1] != '0);
            n_val1 = n_sat1 ? {1'b0, {(COEF_W-1){1'b1}}} : w_dv_quo1[COEF_W-1:0];
        end else begin
            n_sat1 = (w_dv_quo1[NUM_W-1:COEF_W] != '0)
                  || (w_dv_quo1[COEF_W-1] && (w_dv_quo1[COEF_W-2:0] != '0));
            n_val1 = n_sat1 ? {1'b1, {(COEF_W-1){1'b0}}} : -w_dv_quo1[COEF_W-1:0];
        end
        if (!w_dv_side.neg2) begin
            n_sat2 = (w_dv_quo2[NUM_W-1:COEF_W-1] != '0);
            n_val2 = n_sat2 ? {1'b0, {(COEF_W-1){1'b1}}} : w_dv_quo2[COEF_W-1:0];
        end else begin
            n_sat2 = (w_dv_quo2[NUM_W-1:COEF_W] != '0)
                  || (w_dv_quo2[COEF_W-1] && (w_dv_quo2[COEF_W-2:0] != '0));
            n_val2 = n_sat2 ? {1'b1, {(COEF_W-1){1'b0}}} : -w_dv_quo2[COEF_W-1:0];
        end

        if (w_dv_side.zero_lead) begin
            n_rsp.root_kind       = KIND_TWO_REAL;
            n_rsp.first_value     = '0;
            n_rsp.second_value    = '0;
            n_rsp.zero_lead_error = 1'b1;
            n_rsp.saturated       = 1'b0;
        end else begin
            n_rsp.root_kind       = w_dv_side.kind;
            n_rsp.first_value     = n_val1;
            n_rsp.second_value    = n_val2;
            n_rsp.zero_lead_error = 1'b0;
            n_rsp.saturated       = n_sat1 || n_sat2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== rtl/qrs_disc.sv =====
module qrs_disc import qrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_req             i_req,
    output logic             o_valid,
    output logic [RAD_W-1:0] o_rad,
    output t_side            o_side
);

    logic                     r_v1;
    logic [63:0]              r_bb;
    logic signed [63:0]       r_ac;
    logic signed [COEF_W-1:0] r_a;
    logic signed [COEF_W-1:0] r_b;
    logic                     r_v2;
    logic [RAD_W-1:0]         r_rad;
    t_side                    r_side;

    logic signed [66:0] n_disc;
    logic signed [66:0] n_mag;
    t_root_kind         n_kind;

    always_comb begin
        n_disc = $signed({3'b000, r_bb}) - $signed({r_ac[63], r_ac, 2'b00});
        n_mag  = n_disc[66] ? -n_disc : n_disc;
        if (n_disc == '0) begin
            n_kind = KIND_DOUBLE;
        end else if (n_disc[66]) begin
            n_kind = KIND_COMPLEX;
        end else begin
            n_kind = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb             <= 64'(i_req.coef_b * i_req.coef_b);
            r_ac             <= 64'(i_req.coef_a) * 64'(i_req.coef_c);
            r_a              <= i_req.coef_a;
            r_b              <= i_req.coef_b;
            r_rad            <= n_mag[RAD_W-1:0];
            r_side.coef_a    <= r_a;
            r_side.coef_b    <= r_b;
            r_side.zero_lead <= (r_a == '0);
            r_side.kind      <= n_kind;
        end
    end

    assign o_valid = r_v2;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// ===== rtl/qrs_sqrt.sv =====
module qrs_sqrt import qrs_pkg::*; #(
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SBW-1:0]    o_sb
);

    // One result bit per stage, two radicand bits consumed per stage.
    logic              r_v    [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [SBW-1:0]    r_sb   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              w_v;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [RAD_W-1:0]  w_rad;
        logic [SBW-1:0]    w_sb;
        logic [REM_W-1:0]  n_sh;
        logic [REM_W-1:0]  n_trial;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
            assign w_sb   = i_sb;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_sb   = r_sb[k-1];
        end

        assign n_sh    = {w_rem[REM_W-3:0], w_rad[RAD_W-1 -: 2]};
        assign n_trial = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_sh >= n_trial) begin
                    r_rem[k]  <= n_sh - n_trial;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_sh;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
                r_rad[k] <= {w_rad[RAD_W-3:0], 2'b00};
                r_sb[k]  <= w_sb;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_sb    = r_sb[ROOT_W-1];

endmodule

// ===== rtl/qrs_div.sv =====
module qrs_div import qrs_pkg::*; #(
    parameter int NUM_W = 51,
    parameter int SBW   = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [NUM_W-1:0]   i_num1,
    input  logic [NUM_W-1:0]   i_num2,
    input  logic [DIV_D_W-1:0] i_den,
    input  logic [SBW-1:0]     i_sb,
    output logic               o_valid,
    output logic [NUM_W-1:0]   o_quo1,
    output logic [NUM_W-1:0]   o_quo2,
    output logic [SBW-1:0]     o_sb
);

    // Two restoring dividers sharing one divisor, one quotient bit per stage.
    // The numerator shifts out at the top while quotient bits fill in below.
    logic               r_v   [NUM_W];
    logic [DIV_R_W-1:0] r_rem [NUM_W][2];
    logic [NUM_W-1:0]   r_nq  [NUM_W][2];
    logic [DIV_D_W-1:0] r_den [NUM_W];
    logic [SBW-1:0]     r_sb  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic               w_v;
        logic [DIV_D_W-1:0] w_den;
        logic [SBW-1:0]     w_sb;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_den = i_den;
            assign w_sb  = i_sb;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_den = r_den[k-1];
            assign w_sb  = r_sb[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_den;
                r_sb[k]  <= w_sb;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DIV_R_W-1:0] w_rem;
            logic [NUM_W-1:0]   w_nq;
            logic [DIV_R_W-1:0] n_sh;
            logic               n_ge;

            if (k == 0) begin : g_first
                assign w_rem = '0;
                assign w_nq  = (l == 0) ? i_num1 : i_num2;
            end else begin : g_next
                assign w_rem = r_rem[k-1][l];
                assign w_nq  = r_nq[k-1][l];
            end

            assign n_sh = {w_rem[DIV_R_W-2:0], w_nq[NUM_W-1]};
            assign n_ge = (n_sh >= {1'b0, w_den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= n_ge ? (n_sh - {1'b0, w_den}) : n_sh;
                    r_nq[k][l]  <= {w_nq[NUM_W-2:0], n_ge};
                end
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo1  = r_nq[NUM_W-1][0];
    assign o_quo2  = r_nq[NUM_W-1][1];
    assign o_sb    = r_sb[NUM_W-1];

endmodule

// ===== rtl/qrs_checker.sv =====
module qrs_checker import qrs_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_rsp))
        else $error("result changed while stalled");

    // The block only stalls requests when a finished result is blocked.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("request stall without a blocked result");

    // A zero leading coefficient gives zero roots and nothing else.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.zero_lead_error |->
            o_rsp.first_value == '0 && o_rsp.second_value == '0
            && !o_rsp.saturated && o_rsp.root_kind == KIND_TWO_REAL)
        else $error("zero leading coefficient with nonzero result");

    // A double root is reported twice.
    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.root_kind == KIND_DOUBLE |->
            o_rsp.first_value == o_rsp.second_value)
        else $error("double root values differ");

    // No result is left over after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
